// ===== rtl/tivm_pkg.sv =====
// Shared types, opcodes and helpers for the tagged integer execute unit.
// Depends on nothing; every other file imports it.
package tivm_pkg;

    // Storage sizes.
    localparam int NUM_REGS   = 128;
    localparam int POOL_DEPTH = 128;
    localparam int REG_AW     = $clog2(NUM_REGS);
    localparam int POOL_AW    = $clog2(POOL_DEPTH);

    // Datapath sizes for the shared multiply/divide unit.
    localparam int WORD_W   = 64;
    localparam int STEP_CNT = 64;
    localparam int CNT_W    = $clog2(STEP_CNT);

    // Opcodes.
    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_EQ    = 4'd4;
    localparam logic [3:0] OP_GT    = 4'd5;
    localparam logic [3:0] OP_LT    = 4'd6;
    localparam logic [3:0] OP_CJMP  = 4'd7;
    localparam logic [3:0] OP_UJMP  = 4'd8;
    localparam logic [3:0] OP_NJMP  = 4'd9;
    localparam logic [3:0] OP_MOV   = 4'd10;
    localparam logic [3:0] OP_RET   = 4'd11;
    localparam logic [3:0] OP_LOADC = 4'd12;

    typedef struct packed {
        logic [3:0]  op;
        logic [6:0]  dest;
        logic [7:0]  src_b;
        logic [7:0]  src_c;
        logic [31:0] jump_target;
        logic [63:0] const_value;
    } in_word_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [63:0] value;
        logic        halted;
        logic        div_zero;
    } out_word_t;

    // Write request into the operand store.
    typedef struct packed {
        logic        reg_we;
        logic        pool_we;
        logic [6:0]  idx;
        logic [63:0] data;
    } store_wr_t;

    // Command to the shared multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } alu_ctrl_t;

    // Arithmetic shift right by one removes the tag.
    function automatic logic [63:0] untag(input logic [63:0] raw);
        return {raw[63], raw[63:1]};
    endfunction

    // Shift left by one and set the tag bit.
    function automatic logic [63:0] tag(input logic [63:0] n);
        return {n[62:0], 1'b1};
    endfunction

endpackage

// ===== rtl/tivm_opstore.sv =====
// Operand store: register file with per-entry valid bits and the constant pool.
// One registered read port selected by an 8-bit operand number. Uses tivm_pkg.
module tivm_opstore (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          rd_sel,
    input  tivm_pkg::store_wr_t wr,
    output logic [63:0]         rd_data
);
    import tivm_pkg::*;

    logic [63:0]         reg_mem [NUM_REGS];
    logic [63:0]         pool_mem [POOL_DEPTH];
    logic [NUM_REGS-1:0] reg_valid_reg;

    logic [63:0] reg_q_reg;
    logic [63:0] pool_q_reg;
    logic        is_pool_reg;
    logic        reg_ok_reg;
    logic        pool_ok_reg;

    logic wr_reg_ok;
    logic wr_pool_ok;
    logic rd_ok;

    assign wr_reg_ok  = ({1'b0, wr.idx} < 8'(NUM_REGS));
    assign wr_pool_ok = ({1'b0, wr.idx} < 8'(POOL_DEPTH));
    assign rd_ok      = ({1'b0, rd_sel[6:0]} < 8'(NUM_REGS));

    // Valid bits make never-written registers read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reg_valid_reg <= '0;
        end else if (wr.reg_we && wr_reg_ok) begin
            reg_valid_reg[wr.idx[REG_AW-1:0]] <= 1'b1;
        end
    end

    // Memory writes.
    always_ff @(posedge aclk) begin
        if (wr.reg_we && wr_reg_ok) begin
            reg_mem[wr.idx[REG_AW-1:0]] <= wr.data;
        end
        if (wr.pool_we && wr_pool_ok) begin
            pool_mem[wr.idx[POOL_AW-1:0]] <= wr.data;
        end
    end

    // Registered reads of both arrays.
    always_ff @(posedge aclk) begin
        reg_q_reg   <= reg_mem[rd_sel[REG_AW-1:0]];
        pool_q_reg  <= pool_mem[rd_sel[POOL_AW-1:0]];
        is_pool_reg <= rd_sel[7];
        reg_ok_reg  <= rd_ok && reg_valid_reg[rd_sel[REG_AW-1:0]];
        pool_ok_reg <= ({1'b0, rd_sel[6:0]} < 8'(POOL_DEPTH));
    end

    always_comb begin
        if (is_pool_reg) begin
            rd_data = pool_ok_reg ? pool_q_reg : '0;
        end else begin
            rd_data = reg_ok_reg ? reg_q_reg : '0;
        end
    end

endmodule

// ===== rtl/tivm_seqalu.sv =====
// Shared multiply/divide unit: one 65-bit adder used once per cycle for
// shift-add multiplication or restoring division of magnitudes. Uses tivm_pkg.
module tivm_seqalu (
    input  logic                aclk,
    input  logic                aresetn,
    input  tivm_pkg::alu_ctrl_t ctrl,
    input  logic [63:0]         opa,
    input  logic [63:0]         opb,
    output logic                done,
    output logic [63:0]         result
);
    import tivm_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              is_div_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;

    logic [WORD_W-1:0] shift_rem;
    logic [WORD_W-1:0] add_x;
    logic [WORD_W-1:0] add_y;
    logic [WORD_W:0]   sum;

    // The one adder: accumulate for multiply, trial subtract for divide.
    always_comb begin
        shift_rem = {acc_reg[WORD_W-2:0], a_reg[WORD_W-1]};
        add_x     = is_div_reg ? shift_rem : acc_reg;
        add_y     = is_div_reg ? ~b_reg : a_reg;
        sum       = {1'b0, add_x} + {1'b0, add_y} + (WORD_W+1)'(is_div_reg);
    end

    // Step counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEP_CNT - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            acc_reg    <= '0;
            a_reg      <= opa;
            b_reg      <= opb;
            is_div_reg <= ctrl.is_div;
        end else if (busy_reg) begin
            if (is_div_reg) begin
                acc_reg <= sum[WORD_W] ? sum[WORD_W-1:0] : shift_rem;
                a_reg   <= {a_reg[WORD_W-2:0], sum[WORD_W]};
            end else begin
                if (b_reg[0]) begin
                    acc_reg <= sum[WORD_W-1:0];
                end
                a_reg <= {a_reg[WORD_W-2:0], 1'b0};
                b_reg <= {1'b0, b_reg[WORD_W-1:1]};
            end
        end
    end

    assign done   = done_reg;
    assign result = is_div_reg ? a_reg : acc_reg;

    property p_no_start_while_busy;
        @(posedge aclk) disable iff (!aresetn) busy_reg |-> !ctrl.start;
    endproperty
    a_no_start_while_busy: assert property (p_no_start_while_busy)
        else $error("multiply/divide restarted while busy");

    property p_done_ends_busy;
        @(posedge aclk) disable iff (!aresetn) done_reg |-> !busy_reg;
    endproperty
    a_done_ends_busy: assert property (p_done_ends_busy)
        else $error("done raised while still stepping");

    property p_start_busy;
        @(posedge aclk) disable iff (!aresetn) ctrl.start |=> busy_reg && cnt_reg == '0;
    endproperty
    a_start_busy: assert property (p_start_busy)
        else $error("start did not begin a step sequence");

endmodule

// ===== rtl/tagged_int_vm_execute.sv =====
// Execute unit for tagged 63-bit integers: takes one instruction word on s_ and
// returns one result word on m_ with the next pc, written value and flags.
// Plain ops raise m_valid after two operand reads from the registered store,
// execute and output; mul and div with a nonzero divisor also wait in busy for
// the shared one-bit-per-cycle multiply/divide unit's 64 steps. s_ready returns
// in the cycle that m_valid rises; no new word is taken while one is in flight. A
// finished result waits in an output register while the next word is accepted.
module tagged_int_vm_execute (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tivm_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tivm_pkg::out_word_t m_data
);
    import tivm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RDA  = 3'd1;
    localparam logic [2:0] ST_RDC  = 3'd2;
    localparam logic [2:0] ST_EXEC = 3'd3;
    localparam logic [2:0] ST_BUSY = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  state_reg;
    in_word_t    item_reg;
    logic [63:0] opa_reg;
    logic [31:0] pc_reg;
    out_word_t   res_reg;
    logic        neg_reg;
    logic        m_valid_reg;
    out_word_t   m_data_reg;

    logic [7:0]  rd_sel;
    logic [63:0] rd_data;
    store_wr_t   wr;
    alu_ctrl_t   alu_ctrl;
    logic [63:0] alu_opa;
    logic [63:0] alu_opb;
    logic        alu_done;
    logic [63:0] alu_result;

    logic [63:0] b_val;
    logic [63:0] c_val;
    logic        out_free;
    logic        cond_nz;
    logic [31:0] pc_inc1;
    logic [31:0] pc_inc2;
    logic [63:0] quot;

    tivm_opstore u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_sel  (rd_sel),
        .wr      (wr),
        .rd_data (rd_data)
    );

    tivm_seqalu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (alu_ctrl),
        .opa     (alu_opa),
        .opb     (alu_opb),
        .done    (alu_done),
        .result  (alu_result)
    );

    // Operand select: conditional jumps and ret read the dest register, the second read is src_c.
    always_comb begin
        if (state_reg == ST_RDC) begin
            rd_sel = item_reg.src_c;
        end else if (item_reg.op == OP_CJMP || item_reg.op == OP_NJMP
                     || item_reg.op == OP_RET) begin
            rd_sel = {1'b0, item_reg.dest};
        end else begin
            rd_sel = item_reg.src_b;
        end
    end

    // Untagged operands; the second one is still on the store output in execute.
    always_comb begin
        b_val   = untag(opa_reg);
        c_val   = untag(rd_data);
        cond_nz = (opa_reg[63:1] != '0);
        pc_inc1 = pc_reg + 32'd1;
        pc_inc2 = pc_reg + 32'd2;
        quot    = neg_reg ? (64'd0 - alu_result) : alu_result;
    end

    // Launch of the shared unit on magnitudes for div by a nonzero divisor, untagged operands for mul.
    always_comb begin
        alu_ctrl.is_div = (item_reg.op == OP_DIV);
        alu_ctrl.start  = (state_reg == ST_EXEC)
                          && (item_reg.op == OP_MUL
                              || (item_reg.op == OP_DIV && c_val != '0));
        if (item_reg.op == OP_DIV) begin
            alu_opa = b_val[63] ? (64'd0 - b_val) : b_val;
            alu_opb = c_val[63] ? (64'd0 - c_val) : c_val;
        end else begin
            alu_opa = b_val;
            alu_opb = c_val;
        end
    end

    // Store writes happen as the result moves into the output register.
    assign out_free = !m_valid_reg || m_ready;
    always_comb begin
        wr.reg_we  = (state_reg == ST_OUT) && out_free
                     && (item_reg.op <= OP_LT || item_reg.op == OP_MOV);
        wr.pool_we = (state_reg == ST_OUT) && out_free && (item_reg.op == OP_LOADC);
        wr.idx     = item_reg.dest;
        wr.data    = res_reg.value;
    end

    // Control sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_RDA;
                    end
                end
                ST_RDA: begin
                    state_reg <= ST_RDC;
                end
                ST_RDC: begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    state_reg <= alu_ctrl.start ? ST_BUSY : ST_OUT;
                end
                ST_BUSY: begin
                    if (alu_done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        pc_reg    <= res_reg.next_pc;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            item_reg <= s_data;
        end
        if (state_reg == ST_RDC) begin
            opa_reg <= rd_data;
        end
        if (state_reg == ST_EXEC) begin
            neg_reg          <= b_val[63] ^ c_val[63];
            res_reg.next_pc  <= pc_inc1;
            res_reg.value    <= '0;
            res_reg.halted   <= 1'b0;
            res_reg.div_zero <= 1'b0;
            unique case (item_reg.op) inside
                OP_ADD: res_reg.value <= tag(b_val + c_val);
                OP_SUB: res_reg.value <= tag(b_val - c_val);
                OP_DIV: begin
                    if (c_val == '0) begin
                        res_reg.value    <= tag(64'd0);
                        res_reg.div_zero <= 1'b1;
                    end
                end
                OP_EQ: res_reg.value <= tag({63'd0, b_val == c_val});
                OP_GT: res_reg.value <= tag({63'd0, $signed(b_val) > $signed(c_val)});
                OP_LT: res_reg.value <= tag({63'd0, $signed(b_val) < $signed(c_val)});
                OP_CJMP: res_reg.next_pc <= cond_nz ? item_reg.jump_target : pc_inc2;
                OP_NJMP: res_reg.next_pc <= cond_nz ? pc_inc2 : item_reg.jump_target;
                OP_UJMP: res_reg.next_pc <= item_reg.jump_target;
                OP_MOV: res_reg.value <= opa_reg;
                OP_RET: begin
                    res_reg.value   <= opa_reg;
                    res_reg.halted  <= 1'b1;
                    res_reg.next_pc <= pc_reg;
                end
                OP_LOADC: begin
                    res_reg.value   <= item_reg.const_value;
                    res_reg.next_pc <= pc_reg;
                end
                default: begin
                end
            endcase
        end
        if (state_reg == ST_BUSY && alu_done) begin
            res_reg.value <= (item_reg.op == OP_DIV) ? tag(quot) : tag(alu_result);
        end
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    property p_out_holds;
        @(posedge aclk) disable iff (!aresetn)
            state_reg == ST_OUT && m_valid_reg && !m_ready |=> state_reg == ST_OUT;
    endproperty
    a_out_holds: assert property (p_out_holds)
        else $error("result overwrote a word not yet taken");

    property p_done_in_busy;
        @(posedge aclk) disable iff (!aresetn) alu_done |-> state_reg == ST_BUSY;
    endproperty
    a_done_in_busy: assert property (p_done_in_busy)
        else $error("multiply/divide finished outside busy state");

    property p_flags_exclusive;
        @(posedge aclk) disable iff (!aresetn) m_valid |-> !(m_data.halted && m_data.div_zero);
    endproperty
    a_flags_exclusive: assert property (p_flags_exclusive)
        else $error("halted and div_zero both set");

endmodule

// ===== bench/tagged_int_vm_execute_tb.sv =====
// Testbench for the tagged integer execute unit: drives instruction words,
// predicts each result word and compares it field by field. Depends on tivm_pkg.
`timescale 1ns / 100ps

module tagged_int_vm_execute_tb;
    import tivm_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_word_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_word_t   m_data;

    tagged_int_vm_execute i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    localparam logic [63:0] SIGN = 64'h8000_0000_0000_0000;
    localparam int CYCLE_LIMIT = 600000;

    // Shadow state of the machine.
    logic [63:0] regs_q [NUM_REGS];
    logic [63:0] pool_q [POOL_DEPTH];
    bit          pool_written [POOL_DEPTH];
    logic [31:0] pc_q;

    in_word_t  pending_words [$];
    out_word_t expected_words [$];
    int        error_count;
    int        cycle_count;
    int        send_wait;
    int        recv_wait;
    bit        hold_sender;
    bit        stim_done;

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    function automatic logic [63:0] fetch_operand(logic [7:0] sel);
        if (sel >= 8'd128) return pool_q[sel - 8'd128];
        return regs_q[sel[6:0]];
    endfunction

    function automatic logic [63:0] strip_tag(logic [63:0] raw);
        return {raw[63], raw[63:1]};
    endfunction

    function automatic logic [63:0] add_tag(logic [63:0] n);
        return {n[62:0], 1'b1};
    endfunction

    function automatic logic [63:0] quotient_trunc(logic [63:0] a, logic [63:0] b);
        logic [63:0] ma, mb, q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    // Execute one word on the shadow state and return the expected result.
    function automatic out_word_t execute_word(in_word_t w);
        out_word_t r;
        logic [63:0] b, c;
        logic [31:0] nxt;
        nxt = pc_q + 32'd1;
        r = '0;
        b = strip_tag(fetch_operand(w.src_b));
        c = strip_tag(fetch_operand(w.src_c));
        case (w.op)
            OP_ADD: r.value = add_tag(b + c);
            OP_SUB: r.value = add_tag(b - c);
            OP_MUL: r.value = add_tag(b * c);
            OP_DIV: begin
                if (c == 64'd0) begin
                    r.div_zero = 1'b1;
                    r.value = 64'd1;
                end else begin
                    r.value = add_tag(quotient_trunc(b, c));
                end
            end
            OP_EQ: r.value = add_tag({63'd0, b == c});
            OP_GT: r.value = add_tag({63'd0, (c ^ SIGN) < (b ^ SIGN)});
            OP_LT: r.value = add_tag({63'd0, (b ^ SIGN) < (c ^ SIGN)});
            OP_CJMP: nxt = (strip_tag(regs_q[w.dest]) != 0) ? w.jump_target : pc_q + 32'd2;
            OP_UJMP: nxt = w.jump_target;
            OP_NJMP: nxt = (strip_tag(regs_q[w.dest]) == 0) ? w.jump_target : pc_q + 32'd2;
            OP_MOV: r.value = fetch_operand(w.src_b);
            OP_RET: begin
                r.value = regs_q[w.dest];
                r.halted = 1'b1;
                nxt = pc_q;
            end
            OP_LOADC: begin
                pool_q[w.dest] = w.const_value;
                pool_written[w.dest] = 1'b1;
                r.value = w.const_value;
                nxt = pc_q;
            end
            default: ;
        endcase
        if (w.op <= OP_LT || w.op == OP_MOV) regs_q[w.dest] = r.value;
        pc_q = nxt;
        r.next_pc = nxt;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // Source selector that never points at an unwritten pool entry.
    function automatic logic [7:0] pick_source();
        int k;
        if ($urandom_range(0, 2) == 0) begin
            k = $urandom_range(0, 127);
            if (pool_written[k]) return 8'(128 + k);
        end
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 64'h1;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return 64'h8000_0000_0000_0001;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            4: return {32'd0, $urandom} | 64'd1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Queue a word; its expectation is built in issue order when the driver presents it.
    task automatic queue_word(in_word_t w);
        pending_words.push_back(w);
    endtask

    function automatic in_word_t make_word(logic [3:0] op, logic [6:0] d, logic [7:0] b,
                                           logic [7:0] c, logic [31:0] t, logic [63:0] v);
        in_word_t w;
        w.op = op; w.dest = d; w.src_b = b; w.src_c = c;
        w.jump_target = t; w.const_value = v;
        return w;
    endfunction

    // Driver: presents queued words with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait <= 0;
        end else if (s_valid && !s_ready) begin
            // Hold the word until accepted.
        end else if (send_wait > 0) begin
            s_valid <= 1'b0;
            send_wait <= send_wait - 1;
        end else if (pending_words.size() > 0 && !hold_sender) begin
            s_data <= pending_words[0];
            expected_words.push_back(execute_word(pending_words.pop_front()));
            s_valid <= 1'b1;
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Monitor: random backpressure and comparison against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", m_data.value, 64'd0);
                end else begin
                    out_word_t e;
                    e = expected_words.pop_front();
                    if (m_data.next_pc !== e.next_pc)
                        report_mismatch("next_pc", m_data.next_pc, e.next_pc);
                    if (m_data.value !== e.value)
                        report_mismatch("value", m_data.value, e.value);
                    if (m_data.halted !== e.halted)
                        report_mismatch("halted", m_data.halted, e.halted);
                    if (m_data.div_zero !== e.div_zero)
                        report_mismatch("div_zero", m_data.div_zero, e.div_zero);
                end
                recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        in_word_t w;
        int n;
        aresetn = 1'b0;
        hold_sender = 1'b0;
        pc_q = '0;
        for (int i = 0; i < NUM_REGS; i++) regs_q[i] = '0;
        for (int i = 0; i < POOL_DEPTH; i++) begin
            pool_q[i] = '0;
            pool_written[i] = 1'b0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words: pool extremes, every op, divide special cases.
        queue_word(make_word(OP_LOADC, 7'd0, 8'd0, 8'd0, 32'd0, 64'h8000_0000_0000_0001));
        queue_word(make_word(OP_LOADC, 7'd127, 8'd0, 8'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF));
        queue_word(make_word(OP_LOADC, 7'd1, 8'd0, 8'd0, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF));
        queue_word(make_word(OP_LOADC, 7'd2, 8'd0, 8'd0, 32'd0, 64'h1));
        queue_word(make_word(OP_MOV, 7'd127, 8'd255, 8'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF));
        queue_word(make_word(OP_ADD, 7'd3, 8'd129, 8'd129, 32'd0, 64'd0));
        queue_word(make_word(OP_SUB, 7'd4, 8'd128, 8'd129, 32'd0, 64'd0));
        queue_word(make_word(OP_MUL, 7'd5, 8'd129, 8'd129, 32'd0, 64'd0));
        queue_word(make_word(OP_DIV, 7'd6, 8'd128, 8'd255, 32'd0, 64'd0));
        queue_word(make_word(OP_DIV, 7'd7, 8'd129, 8'd130, 32'd0, 64'd0));
        queue_word(make_word(OP_DIV, 7'd8, 8'd128, 8'd129, 32'd0, 64'd0));
        queue_word(make_word(OP_EQ, 7'd9, 8'd129, 8'd129, 32'd0, 64'd0));
        queue_word(make_word(OP_GT, 7'd10, 8'd129, 8'd128, 32'd0, 64'd0));
        queue_word(make_word(OP_LT, 7'd11, 8'd129, 8'd128, 32'd0, 64'd0));
        queue_word(make_word(OP_CJMP, 7'd9, 8'd0, 8'd0, 32'hFFFF_FFFF, 64'd0));
        queue_word(make_word(OP_CJMP, 7'd0, 8'd0, 8'd0, 32'h1234, 64'd0));
        queue_word(make_word(OP_NJMP, 7'd0, 8'd0, 8'd0, 32'h0, 64'd0));
        queue_word(make_word(OP_NJMP, 7'd9, 8'd0, 8'd0, 32'd5, 64'd0));
        queue_word(make_word(OP_UJMP, 7'd0, 8'hFF, 8'hFF, 32'hFFFF_FFFE, 64'd0));
        queue_word(make_word(OP_RET, 7'd3, 8'd0, 8'd0, 32'd0, 64'd0));
        queue_word(make_word(4'd13, 7'd0, 8'd0, 8'd0, 32'd0, 64'd0));
        queue_word(make_word(4'd15, 7'h7F, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));

        // Pause until the directed words have all come back.
        wait (pending_words.size() == 0 && expected_words.size() == 0);
        hold_sender = 1'b1;
        repeat (80) @(posedge aclk);
        hold_sender = 1'b0;

        // Random words; sources are chosen when queued against a shadow of the pool.
        n = 0;
        while (n < 1000) begin
            logic [3:0] op;
            int r;
            r = $urandom_range(0, 99);
            if (r < 10) op = OP_LOADC;
            else if (r < 14) op = OP_MUL;
            else if (r < 18) op = OP_DIV;
            else if (r < 20) op = 4'($urandom_range(13, 15));
            else op = 4'($urandom_range(0, 11));
            w = make_word(op, 7'($urandom), pick_source(), pick_source(), $urandom, rand_word());
            if (op == OP_LOADC) pool_written[w.dest] = 1'b1;
            queue_word(w);
            n++;
            if (pending_words.size() > 20) wait (pending_words.size() < 10);
        end

        wait (pending_words.size() == 0 && expected_words.size() == 0);
        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tivm_pkg.sv
rtl/tivm_opstore.sv
rtl/tivm_seqalu.sv
rtl/tagged_int_vm_execute.sv
bench/tagged_int_vm_execute_tb.sv
